// ===== hdl/line_number_program_encoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// line-number program encoder assertion macros
// shared assertion forms for the encoder top level
// ----------------------------------------------------------------------------
`ifndef LINE_NUMBER_PROGRAM_ENCODER_TOP_DEFINES_SVH
`define LINE_NUMBER_PROGRAM_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LNPE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lnpe assertion failed");

// next-cycle implication, disabled during reset
`define LNPE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lnpe assertion failed");

`endif

// ===== hdl/lnpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lnpe_pkg
// types and constants shared by the line-number program encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnpe_pkg;

	localparam int IN_TDATA_W = 80;

	localparam int LN_BASE   = -5;
	localparam int LN_RANGE  = 14;
	localparam int LN_OPBASE = 13;
	localparam int LN_MAXOP  = 255;

	localparam logic [7:0] OP_END       = 8'h00;
	localparam logic [7:0] OP_EXT_LEN   = 8'h01;
	localparam logic [7:0] OP_END_SEQ   = 8'h01;
	localparam logic [7:0] OP_COPY      = 8'h01;
	localparam logic [7:0] OP_ADV_PC    = 8'h02;
	localparam logic [7:0] OP_ADV_LINE  = 8'h03;
	localparam logic [7:0] OP_SET_FILE  = 8'h04;
	localparam logic [7:0] SPECIAL_MIN  = 8'(LN_OPBASE);

	typedef struct packed {
		logic        end_seq;
		logic        file_chg;
		logic [15:0] file_num;
		logic        special;
		logic [7:0]  sp_op;
		logic        ad_nz;
		logic [31:0] addr_step;
		logic        ld_nz;
		logic [31:0] line_step;
	} lnpe_cmd_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} lnpe_q_status_t;

endpackage

// ===== hdl/lnpe_fifo.sv =====
// ----------------------------------------------------------------------------
// lnpe_fifo
// two-entry command queue between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnpe_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  lnpe_pkg::lnpe_cmd_t       push_cmd,
	input  logic                      pop,
	output lnpe_pkg::lnpe_cmd_t       head,
	output lnpe_pkg::lnpe_q_status_t  status
);
	import lnpe_pkg::*;

	lnpe_cmd_t   mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign head             = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != 2'd0);
	assign status.full      = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/lnpe_front.sv =====
// ----------------------------------------------------------------------------
// lnpe_front
// accepts rows, tracks the line-machine state and classifies each row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnpe_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// row_address [31:0], line_number [63:32], file_index [79:64]
	input  logic [lnpe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// action [0]
	input  logic                                 s_axis_tuser,
	input  lnpe_pkg::lnpe_q_status_t             q_status,
	output logic                                 push,
	output lnpe_pkg::lnpe_cmd_t                  cmd
);
	import lnpe_pkg::*;

	logic [31:0] last_address_q;
	logic [31:0] last_line_q;
	logic [15:0] last_file_q;

	logic        accept;
	logic [31:0] row_address;
	logic [31:0] line_number;
	logic [15:0] file_index;
	logic        skip;
	logic [31:0] ad;
	logic [31:0] ld;
	logic [31:0] line_ofs;
	logic [9:0]  sp_wide;
	logic        special;

	assign row_address = s_axis_tdata[31:0];
	assign line_number = s_axis_tdata[63:32];
	assign file_index  = s_axis_tdata[79:64];

	assign s_axis_tready = ~q_status.full;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign skip          = line_number[31] | (line_number == 32'd0);
	assign push          = accept & (s_axis_tuser | ~skip);

	assign ad       = row_address - last_address_q;
	assign ld       = line_number - last_line_q;
	assign line_ofs = ld - 32'(LN_BASE);
	assign sp_wide  = 10'(line_ofs[3:0]) + 10'(ad[4:0]) * 10'(LN_RANGE) + 10'(LN_OPBASE);
	assign special  = (line_ofs <= 32'(LN_RANGE - 1)) && (ad[31:5] == 27'd0)
		&& (sp_wide <= 10'(LN_MAXOP));

	always_comb begin
		cmd.end_seq   = s_axis_tuser;
		cmd.file_chg  = (file_index != last_file_q);
		cmd.file_num  = file_index;
		cmd.special   = special;
		cmd.sp_op     = sp_wide[7:0];
		cmd.ad_nz     = (ad != 32'd0);
		cmd.addr_step = ad;
		cmd.ld_nz     = (ld != 32'd0);
		cmd.line_step = ld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_address_q <= 32'd0;
			last_line_q    <= 32'd1;
			last_file_q    <= 16'd0;
		end else if (accept) begin
			if (s_axis_tuser) begin
				last_address_q <= 32'd0;
				last_line_q    <= 32'd1;
				last_file_q    <= 16'd0;
			end else if (!skip) begin
				last_address_q <= row_address;
				last_line_q    <= line_number;
				last_file_q    <= file_index;
			end
		end
	end

endmodule

// ===== hdl/lnpe_back.sv =====
// ----------------------------------------------------------------------------
// lnpe_back
// turns queued commands into the opcode byte stream, one byte per cycle while the receiver is ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnpe_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lnpe_pkg::lnpe_cmd_t       head,
	input  lnpe_pkg::lnpe_q_status_t  q_status,
	output logic                      pop,
	output logic                      busy,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// out_byte [7:0]
	output logic [7:0]                m_axis_tdata,
	output logic                      m_axis_tlast
);
	import lnpe_pkg::*;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_END0  = 4'd1;
	localparam logic [3:0] PH_END1  = 4'd2;
	localparam logic [3:0] PH_END2  = 4'd3;
	localparam logic [3:0] PH_FOP   = 4'd4;
	localparam logic [3:0] PH_FVAL  = 4'd5;
	localparam logic [3:0] PH_SP    = 4'd6;
	localparam logic [3:0] PH_PCOP  = 4'd7;
	localparam logic [3:0] PH_PCVAL = 4'd8;
	localparam logic [3:0] PH_LNOP  = 4'd9;
	localparam logic [3:0] PH_LNVAL = 4'd10;
	localparam logic [3:0] PH_COPY  = 4'd11;

	function automatic logic [3:0] after_line(input lnpe_cmd_t d);
		after_line = d.ld_nz ? PH_LNOP : PH_COPY;
	endfunction

	function automatic logic [3:0] after_file(input lnpe_cmd_t d);
		if (d.special) begin
			after_file = PH_SP;
		end else if (d.ad_nz) begin
			after_file = PH_PCOP;
		end else begin
			after_file = after_line(d);
		end
	endfunction

	function automatic logic [3:0] first_phase(input lnpe_cmd_t d);
		if (d.end_seq) begin
			first_phase = PH_END0;
		end else if (d.file_chg) begin
			first_phase = PH_FOP;
		end else begin
			first_phase = after_file(d);
		end
	endfunction

	logic [3:0]  phase_q;
	lnpe_cmd_t   desc_q;
	logic [63:0] val_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        adv;
	logic        is_last;
	logic [6:0]  grp;
	logic [63:0] shifted;
	logic        leb_done;
	logic [7:0]  byte_nxt;
	logic [3:0]  phase_nxt;
	logic [63:0] val_nxt;

	assign busy    = (phase_q != PH_IDLE);
	assign adv     = busy & (~out_valid_q | m_axis_tready);
	assign is_last = (phase_q == PH_SP) | (phase_q == PH_COPY) | (phase_q == PH_END2);
	assign pop     = q_status.not_empty & (~busy | (adv & is_last));

	assign grp     = val_q[6:0];
	assign shifted = (phase_q == PH_LNVAL) ? {{7{val_q[63]}}, val_q[63:7]}
		: {7'd0, val_q[63:7]};
	assign leb_done = (phase_q == PH_LNVAL)
		? (((shifted == 64'd0) & ~grp[6]) | ((shifted == '1) & grp[6]))
		: (shifted == 64'd0);

	always_comb begin
		byte_nxt  = OP_COPY;
		phase_nxt = phase_q;
		val_nxt   = val_q;
		case (phase_q)
			PH_END0: begin
				byte_nxt  = OP_END;
				phase_nxt = PH_END1;
			end
			PH_END1: begin
				byte_nxt  = OP_EXT_LEN;
				phase_nxt = PH_END2;
			end
			PH_END2: begin
				byte_nxt  = OP_END_SEQ;
				phase_nxt = PH_IDLE;
			end
			PH_FOP: begin
				byte_nxt  = OP_SET_FILE;
				phase_nxt = PH_FVAL;
				val_nxt   = {48'd0, desc_q.file_num};
			end
			PH_FVAL: begin
				byte_nxt  = {~leb_done, grp};
				phase_nxt = leb_done ? after_file(desc_q) : PH_FVAL;
				val_nxt   = shifted;
			end
			PH_SP: begin
				byte_nxt  = desc_q.sp_op;
				phase_nxt = PH_IDLE;
			end
			PH_PCOP: begin
				byte_nxt  = OP_ADV_PC;
				phase_nxt = PH_PCVAL;
				val_nxt   = {{32{desc_q.addr_step[31]}}, desc_q.addr_step};
			end
			PH_PCVAL: begin
				byte_nxt  = {~leb_done, grp};
				phase_nxt = leb_done ? after_line(desc_q) : PH_PCVAL;
				val_nxt   = shifted;
			end
			PH_LNOP: begin
				byte_nxt  = OP_ADV_LINE;
				phase_nxt = PH_LNVAL;
				val_nxt   = {{32{desc_q.line_step[31]}}, desc_q.line_step};
			end
			PH_LNVAL: begin
				byte_nxt  = {~leb_done, grp};
				phase_nxt = leb_done ? PH_COPY : PH_LNVAL;
				val_nxt   = shifted;
			end
			PH_COPY: begin
				byte_nxt  = OP_COPY;
				phase_nxt = PH_IDLE;
			end
			default: begin
				byte_nxt  = OP_COPY;
				phase_nxt = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= head;
		end
		if (adv) begin
			val_q      <= val_nxt;
			out_byte_q <= byte_nxt;
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= first_phase(head);
			end else if (adv) begin
				phase_q <= phase_nxt;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/line_number_program_encoder_top.sv =====
// ----------------------------------------------------------------------------
// line_number_program_encoder_top
// line-number program body encoder: rows in, opcode bytes out
// ----------------------------------------------------------------------------
// rows enter on the s_axis channel (tuser = end-sequence request, tdata =
// address, line, file); program bytes leave on m_axis, one per transaction,
// with tlast on the final byte caused by each input transaction
// the front end updates the line-machine state as it accepts a row and
// queues a command in a two-entry queue; rows with a non-positive line and
// no end-sequence request are accepted and dropped
// the back end emits one byte per cycle while the receiver is ready and
// starts the next queued command in the cycle after the last byte of the
// previous one; an item has 1 to 22 bytes
// a row's bytes pass the queue, the command register and the output register
// the byte serialiser sets the throughput; input stalls only with the queue full
// reset clears the line state (address 0, line 1, file 0) and empties the queue
// a stalled receiver holds the output byte; the queue then fills and tready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_number_program_encoder_top_defines.svh"

module line_number_program_encoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// row_address [31:0], line_number [63:32], file_index [79:64]
	input  logic [lnpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// action [0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_byte [7:0]
	output logic [7:0]                       m_axis_tdata,
	// last_byte
	output logic                             m_axis_tlast
);
	import lnpe_pkg::*;

	logic           push;
	logic           pop;
	logic           back_busy;
	lnpe_cmd_t      push_cmd;
	lnpe_cmd_t      head;
	lnpe_q_status_t q_status;

	lnpe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.push          (push),
		.cmd           (push_cmd)
	);

	lnpe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	lnpe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.busy          (back_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	`LNPE_ASSERT_NOW(a_last_byte_kind, m_axis_tvalid && m_axis_tlast, (m_axis_tdata == OP_COPY) || (m_axis_tdata >= SPECIAL_MIN))
	`LNPE_ASSERT_NEXT(a_queue_drains, q_status.not_empty && !back_busy, back_busy)
	`LNPE_ASSERT_NEXT(a_no_spurious_start, !q_status.not_empty && !back_busy, !back_busy)

endmodule
